### rtl/ieee802154_rx_filter_autoack_unit_defines.svh
// Assertion macros for the 802.15.4 receive filter and auto-ack unit.
// Both macros expect signals named clk and rst in the using module.
`ifndef IEEE802154_RX_FILTER_AUTOACK_UNIT_DEFINES_SVH
`define IEEE802154_RX_FILTER_AUTOACK_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define I154RF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define I154RF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/i154rf_pkg.sv
// Shared types, constants and helpers for the 802.15.4 receive filter.
// No dependencies; used by i154rf_capture and the top level.
`default_nettype none

package i154rf_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 127;
  localparam int LEN_W = 7;      // holds any frame length up to 127
  localparam int POS6_W = 6;     // width of security and command positions

  // Configuration register indexes.
  localparam logic [1:0] REG_PAN_ID      = 2'd0;
  localparam logic [1:0] REG_SHORT_ADDR  = 2'd1;
  localparam logic [1:0] REG_EXT_ADDR    = 2'd2;
  localparam logic [1:0] REG_PROMISCUOUS = 2'd3;

  // Addressing modes and frame fields.
  localparam logic [1:0]  ADDR_MODE_NONE  = 2'd0;
  localparam logic [1:0]  ADDR_MODE_SHORT = 2'd2;
  localparam logic [1:0]  ADDR_MODE_EXT   = 2'd3;
  localparam logic [2:0]  FRAME_TYPE_CMD  = 3'd3;
  localparam logic [7:0]  CMD_DATA_REQ    = 8'd4;
  localparam logic [15:0] BCAST_ID        = 16'hffff;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic       verdict;
    logic       send_ack;
    logic       ack_pending_bit;
    logic [7:0] ack_seq;
  } out_item_t;

  // Header view after the current byte has been taken in.
  typedef struct packed {
    logic [15:0]      frame_ctrl;
    logic [7:0]       seq_num;
    logic [15:0]      dest_pan;
    logic [63:0]      dest_addr;
    logic             is_data_req;
    logic [LEN_W-1:0] len;
  } hdr_t;

  // Key identifier length by key id mode.
  function automatic logic [POS6_W-1:0] key_len(input logic [1:0] mode);
    logic [POS6_W-1:0] n;
    case (mode)
      2'd0: n = 6'd0;
      2'd1: n = 6'd1;
      2'd2: n = 6'd5;
      2'd3: n = 6'd9;
      default: n = 6'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

### rtl/ieee802154_rx_filter_autoack_unit.sv
// Top level of the 802.15.4 receive address filter with auto-ack decision.
// Uses i154rf_pkg, i154rf_capture and the assertion macro header.
//
//   Channel  Direction  Handshake              Contents
//   in       input      in_valid / in_ready    in_item_t: frame_byte, is_last
//   out      output     out_valid / out_ready  out_item_t: verdict, ack fields
//   cfg      input      cfg_we                 cfg_index, cfg_data (64 bits)
//
// One byte is taken per cycle while in_ready is high; the header update and
// the verdict for a final byte are computed in that same cycle and land in the
// output register; the result appears in the cycle after that byte is taken.
// in_ready is low only while a result sits unaccepted and out_ready is low.
// Synchronous reset clears all state but out_data; no clearing pass.
`default_nettype none

`include "ieee802154_rx_filter_autoack_unit_defines.svh"

module ieee802154_rx_filter_autoack_unit #(
  parameter int MAX_FRAME_BYTES = i154rf_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire i154rf_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output i154rf_pkg::out_item_t      out_data,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [63:0]           cfg_data
);

  localparam int LW = i154rf_pkg::LEN_W;

  logic [15:0] pan_id;
  logic [15:0] short_addr;
  logic [63:0] ext_addr;
  logic        promiscuous;

  logic                  in_fire;
  i154rf_pkg::hdr_t      hdr;
  i154rf_pkg::out_item_t result;
  logic [1:0]            dmode;
  logic                  pan_ok;
  logic                  ok;
  logic                  ack;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  i154rf_capture #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_capture (
    .clk        (clk),
    .rst        (rst),
    .step       (in_fire),
    .frame_byte (in_data.frame_byte),
    .is_last    (in_data.is_last),
    .hdr        (hdr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pan_id      <= '0;
      short_addr  <= '0;
      ext_addr    <= '0;
      promiscuous <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        i154rf_pkg::REG_PAN_ID:      pan_id      <= cfg_data[15:0];
        i154rf_pkg::REG_SHORT_ADDR:  short_addr  <= cfg_data[15:0];
        i154rf_pkg::REG_EXT_ADDR:    ext_addr    <= cfg_data;
        i154rf_pkg::REG_PROMISCUOUS: promiscuous <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dmode  = hdr.frame_ctrl[11:10];
    pan_ok = (hdr.dest_pan == i154rf_pkg::BCAST_ID) || (hdr.dest_pan == pan_id);
    if (promiscuous) begin
      ok = 1'b1;
    end else if (hdr.len < LW'(3)) begin
      ok = 1'b0;
    end else begin
      case (dmode)
        i154rf_pkg::ADDR_MODE_NONE:  ok = 1'b1;
        i154rf_pkg::ADDR_MODE_SHORT: ok = (hdr.len >= LW'(7)) && pan_ok &&
                                          ((hdr.dest_addr[15:0] == i154rf_pkg::BCAST_ID) ||
                                           (hdr.dest_addr[15:0] == short_addr));
        i154rf_pkg::ADDR_MODE_EXT:   ok = (hdr.len >= LW'(13)) && pan_ok &&
                                          (hdr.dest_addr == ext_addr);
        default:                     ok = 1'b0;
      endcase
    end
    ack = ok && !promiscuous && hdr.frame_ctrl[5];
    result.verdict         = !ok;
    result.send_ack        = ack;
    result.ack_pending_bit = ack && hdr.is_data_req;
    result.ack_seq         = ack ? hdr.seq_num : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && in_data.is_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.is_last) begin
      out_data <= result;
    end
  end

  `I154RF_ASSERT_NOW(a_no_ack_on_reject, out_valid && out_data.verdict, !out_data.send_ack, "ack on a rejected frame")
  `I154RF_ASSERT_NOW(a_idle_ack_fields, out_valid && !out_data.send_ack, out_data.ack_pending_bit == 1'b0 && out_data.ack_seq == 8'h00, "ack fields set without ack")
  `I154RF_ASSERT_NEXT(a_last_gives_result, in_fire && in_data.is_last, out_valid, "final byte gave no result")
  `I154RF_ASSERT_NEXT(a_mid_byte_quiet, in_fire && !in_data.is_last && !out_valid, !out_valid, "result from a non-final byte")

endmodule

`default_nettype wire

### rtl/i154rf_capture.sv
// Header capture for the 802.15.4 receive filter: tracks the byte position,
// keeps header fields and finds the MAC command id. Uses i154rf_pkg.
`default_nettype none

module i154rf_capture #(
  parameter int MAX_FRAME_BYTES = i154rf_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        frame_byte,
  input  wire logic              is_last,
  output i154rf_pkg::hdr_t       hdr
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int LW = i154rf_pkg::LEN_W;
  localparam int PW = i154rf_pkg::POS6_W;

  logic [POS_W-1:0] byte_pos, byte_pos_next;
  logic [15:0]      frame_ctrl, frame_ctrl_next;
  logic [7:0]       seq_num, seq_num_next;
  logic [15:0]      dest_pan, dest_pan_next;
  logic [63:0]      dest_addr, dest_addr_next;
  logic [PW-1:0]    sec_ctrl_pos, sec_ctrl_pos_next;
  logic [PW-1:0]    cmd_pos, cmd_pos_next;
  logic             is_data_req, is_data_req_next;

  logic [LW-1:0]    pos;
  logic [LW-1:0]    len;
  logic [2:0]       addr_idx;
  logic [1:0]       dmode;
  logic [1:0]       smode;
  logic [PW-1:0]    loc;

  assign pos = LW'(byte_pos);
  assign addr_idx = 3'(pos - LW'(5));

  always_comb begin
    byte_pos_next     = byte_pos;
    frame_ctrl_next   = frame_ctrl;
    seq_num_next      = seq_num;
    dest_pan_next     = dest_pan;
    dest_addr_next    = dest_addr;
    sec_ctrl_pos_next = sec_ctrl_pos;
    cmd_pos_next      = cmd_pos;
    is_data_req_next  = is_data_req;
    len   = LW'(MAX_FRAME_BYTES);
    dmode = 2'd0;
    smode = 2'd0;
    loc   = '0;
    if (pos < LW'(MAX_FRAME_BYTES)) begin
      len = pos + LW'(1);
      byte_pos_next = byte_pos + POS_W'(1);
      if (pos == LW'(0)) begin
        frame_ctrl_next = {8'h00, frame_byte};
      end else if (pos == LW'(1)) begin
        frame_ctrl_next = {frame_byte, frame_ctrl[7:0]};
        dmode = frame_ctrl_next[11:10];
        smode = frame_ctrl_next[15:14];
        sec_ctrl_pos_next = '0;
        cmd_pos_next = '0;
        // Only a command frame with both addresses present can be a data request.
        if (frame_ctrl_next[2:0] == i154rf_pkg::FRAME_TYPE_CMD && dmode[1] && smode[1]) begin
          loc = PW'(3);
          loc = loc + ((dmode == i154rf_pkg::ADDR_MODE_SHORT) ? PW'(4) : PW'(10));
          loc = loc + (frame_ctrl_next[6] ? PW'(0) : PW'(2));
          loc = loc + ((smode == i154rf_pkg::ADDR_MODE_SHORT) ? PW'(2) : PW'(8));
          sec_ctrl_pos_next = frame_ctrl_next[3] ? loc : '0;
          cmd_pos_next = loc;
        end
      end else if (pos == LW'(2)) begin
        seq_num_next = frame_byte;
      end else if (pos == LW'(3)) begin
        dest_pan_next = {8'h00, frame_byte};
      end else if (pos == LW'(4)) begin
        dest_pan_next = {frame_byte, dest_pan[7:0]};
      end else if (pos <= LW'(12)) begin
        dest_addr_next[addr_idx*8 +: 8] = dest_addr[addr_idx*8 +: 8] | frame_byte;
      end

      if (cmd_pos != '0 && pos >= LW'(3)) begin
        // The security control byte moves the command id past the aux header.
        if (sec_ctrl_pos != '0 && pos == LW'(sec_ctrl_pos)) begin
          cmd_pos_next = sec_ctrl_pos + PW'(5) + i154rf_pkg::key_len(frame_byte[4:3]);
        end else if (pos == LW'(cmd_pos)) begin
          is_data_req_next = (frame_byte == i154rf_pkg::CMD_DATA_REQ);
        end
      end
    end
  end

  always_comb begin
    hdr.frame_ctrl  = frame_ctrl_next;
    hdr.seq_num     = seq_num_next;
    hdr.dest_pan    = dest_pan_next;
    hdr.dest_addr   = dest_addr_next;
    hdr.is_data_req = is_data_req_next;
    hdr.len         = len;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && is_last)) begin
      byte_pos     <= '0;
      frame_ctrl   <= '0;
      seq_num      <= '0;
      dest_pan     <= '0;
      dest_addr    <= '0;
      sec_ctrl_pos <= '0;
      cmd_pos      <= '0;
      is_data_req  <= 1'b0;
    end else if (step) begin
      byte_pos     <= byte_pos_next;
      frame_ctrl   <= frame_ctrl_next;
      seq_num      <= seq_num_next;
      dest_pan     <= dest_pan_next;
      dest_addr    <= dest_addr_next;
      sec_ctrl_pos <= sec_ctrl_pos_next;
      cmd_pos      <= cmd_pos_next;
      is_data_req  <= is_data_req_next;
    end
  end

endmodule

`default_nettype wire

### tb/ieee802154_rx_filter_autoack_unit_tb.sv
// Self-checking testbench for the 802.15.4 receive filter and auto-ack unit.
// Depends on i154rf_pkg and the ieee802154_rx_filter_autoack_unit top level only.
// A directed byte table runs first, then random frames under several register settings.
`timescale 1ns / 100ps

module ieee802154_rx_filter_autoack_unit_tb;

  localparam int MAX_BYTES     = i154rf_pkg::MAX_FRAME_BYTES_DEF;
  localparam int QUIET_LIMIT   = 2000;
  localparam int REPORT_LIMIT  = 10;
  localparam int MIN_LEN_ANY   = 3;
  localparam int MIN_LEN_SHORT = 7;
  localparam int MIN_LEN_EXT   = 13;
  localparam int KEY_ID_BYTES [4] = '{0, 1, 5, 9};

  localparam logic [2:0] FRAME_TYPE_DATA    = 3'd1;
  localparam logic [1:0] ADDR_MODE_RESERVED = 2'd1;
  localparam logic       VERDICT_ACCEPT     = 1'b0;
  localparam logic       VERDICT_REJECT     = 1'b1;

  localparam i154rf_pkg::out_item_t NO_VERDICT    = '0;
  localparam i154rf_pkg::out_item_t REJECT_NO_ACK = '{VERDICT_REJECT, 1'b0, 1'b0, 8'h00};

  typedef struct packed {
    logic [7:0]            frame_byte;
    logic                  is_last;
    logic                  typed;
    i154rf_pkg::out_item_t want;
  } dir_row_t;

  // Registers during this table: PAN 0x1234, short address 0xabcd.
  localparam int DIRECTED_LEN = 23;
  localparam dir_row_t DIRECTED [DIRECTED_LEN] = '{
    // One-byte frames are too short for any header.
    '{8'hff, 1'b1, 1'b1, REJECT_NO_ACK},
    '{8'h00, 1'b1, 1'b1, REJECT_NO_ACK},
    // Data frame with no destination, ack requested.
    '{8'h21, 1'b0, 1'b0, NO_VERDICT},
    '{8'h00, 1'b0, 1'b0, NO_VERDICT},
    '{8'h5a, 1'b1, 1'b1, '{VERDICT_ACCEPT, 1'b1, 1'b0, 8'h5a}},
    // Reserved destination addressing mode.
    '{8'h21, 1'b0, 1'b0, NO_VERDICT},
    '{8'h04, 1'b0, 1'b0, NO_VERDICT},
    '{8'h11, 1'b1, 1'b1, REJECT_NO_ACK},
    // Short destination, but the frame ends after the PAN, before the address.
    '{8'h21, 1'b0, 1'b0, NO_VERDICT},
    '{8'h08, 1'b0, 1'b0, NO_VERDICT},
    '{8'h10, 1'b0, 1'b0, NO_VERDICT},
    '{8'h34, 1'b0, 1'b0, NO_VERDICT},
    '{8'h12, 1'b1, 1'b1, REJECT_NO_ACK},
    // MAC data request to our short address with PAN compression.
    '{8'h63, 1'b0, 1'b0, NO_VERDICT},
    '{8'h88, 1'b0, 1'b0, NO_VERDICT},
    '{8'h77, 1'b0, 1'b0, NO_VERDICT},
    '{8'h34, 1'b0, 1'b0, NO_VERDICT},
    '{8'h12, 1'b0, 1'b0, NO_VERDICT},
    '{8'hcd, 1'b0, 1'b0, NO_VERDICT},
    '{8'hab, 1'b0, 1'b0, NO_VERDICT},
    '{8'h01, 1'b0, 1'b0, NO_VERDICT},
    '{8'h80, 1'b0, 1'b0, NO_VERDICT},
    '{8'h04, 1'b1, 1'b0, NO_VERDICT}
  };

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  i154rf_pkg::in_item_t  in_data;
  logic                  out_valid;
  logic                  out_ready;
  i154rf_pkg::out_item_t out_data;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [63:0]           cfg_data;

  ieee802154_rx_filter_autoack_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;

  i154rf_pkg::out_item_t verdict_q [$];
  logic [7:0]            frame_buf [0:159];
  int                    frame_len;

  // Register copies used by the predictor and the frame builder.
  logic [15:0] own_pan = '0;
  logic [15:0] own_short = '0;
  logic [63:0] own_ext = '0;
  logic        own_promisc = 1'b0;

  // Header state of the frame in flight.
  logic [6:0]  hdr_pos = '0;
  logic [15:0] hdr_fc = '0;
  logic [7:0]  hdr_seq = '0;
  logic [15:0] hdr_pan = '0;
  logic [63:0] hdr_daddr = '0;
  logic [5:0]  hdr_sec_pos = '0;
  logic [5:0]  hdr_cmd_pos = '0;
  logic        hdr_data_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Takes one byte into the header state; on the final byte it gives the verdict.
  task automatic judge_byte(input i154rf_pkg::in_item_t it, output bit has_verdict,
                            output i154rf_pkg::out_item_t res);
    logic [7:0] b;
    logic [1:0] dm;
    logic [1:0] sm;
    logic       pan_ok;
    logic       ok;
    logic       ack;
    int         pos;
    int         len;
    int         p;
    b = it.frame_byte;
    pos = hdr_pos;
    has_verdict = 1'b0;
    res = '0;
    if (pos < MAX_BYTES) begin
      if (pos == 0) begin
        hdr_fc = {8'h00, b};
      end else if (pos == 1) begin
        hdr_fc[15:8] = b;
        dm = hdr_fc[11:10];
        sm = hdr_fc[15:14];
        hdr_sec_pos = '0;
        hdr_cmd_pos = '0;
        if (hdr_fc[2:0] == i154rf_pkg::FRAME_TYPE_CMD &&
            dm >= i154rf_pkg::ADDR_MODE_SHORT && sm >= i154rf_pkg::ADDR_MODE_SHORT) begin
          // Control, sequence, destination PAN and address, source PAN unless
          // compressed, then the source address.
          p = 3 + ((dm == i154rf_pkg::ADDR_MODE_SHORT) ? 4 : 10) + (hdr_fc[6] ? 0 : 2) +
              ((sm == i154rf_pkg::ADDR_MODE_SHORT) ? 2 : 8);
          hdr_cmd_pos = 6'(p);
          if (hdr_fc[3]) begin
            hdr_sec_pos = 6'(p);
          end
        end
      end else if (pos == 2) begin
        hdr_seq = b;
      end else if (pos == 3) begin
        hdr_pan[7:0] = b;
      end else if (pos == 4) begin
        hdr_pan[15:8] = b;
      end else if (pos <= 12) begin
        hdr_daddr[8*(pos-5) +: 8] = b;
      end
      if (hdr_cmd_pos != 0 && pos >= 3) begin
        if (hdr_sec_pos != 0 && pos == hdr_sec_pos) begin
          // The auxiliary security header moves the command id further out.
          hdr_cmd_pos = 6'(hdr_sec_pos + 5 + KEY_ID_BYTES[b[4:3]]);
        end else if (pos == hdr_cmd_pos) begin
          hdr_data_req = (b == i154rf_pkg::CMD_DATA_REQ);
        end
      end
      hdr_pos = hdr_pos + 7'd1;
      len = pos + 1;
    end else begin
      len = MAX_BYTES;
    end
    if (!it.is_last) begin
      return;
    end

    dm = hdr_fc[11:10];
    pan_ok = (hdr_pan == i154rf_pkg::BCAST_ID) || (hdr_pan == own_pan);
    if (own_promisc) begin
      ok = 1'b1;
    end else if (len < MIN_LEN_ANY) begin
      ok = 1'b0;
    end else if (dm == i154rf_pkg::ADDR_MODE_NONE) begin
      ok = 1'b1;
    end else if (dm == i154rf_pkg::ADDR_MODE_SHORT) begin
      ok = len >= MIN_LEN_SHORT && pan_ok &&
           (hdr_daddr[15:0] == i154rf_pkg::BCAST_ID || hdr_daddr[15:0] == own_short);
    end else if (dm == i154rf_pkg::ADDR_MODE_EXT) begin
      ok = len >= MIN_LEN_EXT && pan_ok && hdr_daddr == own_ext;
    end else begin
      ok = 1'b0;
    end
    ack = ok && !own_promisc && hdr_fc[5];
    res.verdict = ok ? VERDICT_ACCEPT : VERDICT_REJECT;
    res.send_ack = ack;
    res.ack_pending_bit = ack & hdr_data_req;
    res.ack_seq = ack ? hdr_seq : 8'h00;
    has_verdict = 1'b1;

    hdr_pos = '0;
    hdr_fc = '0;
    hdr_seq = '0;
    hdr_pan = '0;
    hdr_daddr = '0;
    hdr_sec_pos = '0;
    hdr_cmd_pos = '0;
    hdr_data_req = 1'b0;
  endtask

  // Entered and left at a falling edge. A typed row overrides the prediction.
  task automatic send_byte(input logic [7:0] b, input logic end_of_frame, input logic typed,
                           input i154rf_pkg::out_item_t want);
    bit                    has_verdict;
    i154rf_pkg::out_item_t res;
    if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{frame_byte: b, is_last: end_of_frame};
    do @(posedge clk); while (!in_ready);
    judge_byte(in_data, has_verdict, res);
    if (has_verdict) begin
      verdict_q.push_back(typed ? want : res);
    end
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [63:0] pan, input logic [63:0] shrt,
                              input logic [63:0] ext, input logic [63:0] prom);
    cfg_we <= 1'b1;
    cfg_index <= i154rf_pkg::REG_PAN_ID;
    cfg_data <= pan;
    @(negedge clk);
    cfg_index <= i154rf_pkg::REG_SHORT_ADDR;
    cfg_data <= shrt;
    @(negedge clk);
    cfg_index <= i154rf_pkg::REG_EXT_ADDR;
    cfg_data <= ext;
    @(negedge clk);
    cfg_index <= i154rf_pkg::REG_PROMISCUOUS;
    cfg_data <= prom;
    @(negedge clk);
    cfg_we <= 1'b0;
    own_pan = pan[15:0];
    own_short = shrt[15:0];
    own_ext = ext;
    own_promisc = prom[0];
  endtask

  // The unit is idle once every verdict is in.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_byte(input logic [7:0] b);
    frame_buf[frame_len] = b;
    frame_len++;
  endtask

  // Mostly well-formed frames aimed at our addresses; some noise, cut-off and overlong ones.
  task automatic build_frame();
    int          pick;
    int          k;
    logic [2:0]  ftype;
    logic [1:0]  dm;
    logic [1:0]  sm;
    logic        sec;
    logic        pcomp;
    logic [7:0]  sc;
    logic [15:0] id;
    logic [63:0] xa;
    frame_len = 0;
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 20)) put_byte(8'($urandom));
      return;
    end
    pick = $urandom_range(0, 9);
    ftype = (pick < 6) ? i154rf_pkg::FRAME_TYPE_CMD :
            (pick < 9) ? FRAME_TYPE_DATA : 3'($urandom);
    pick = $urandom_range(0, 9);
    dm = (pick == 0) ? i154rf_pkg::ADDR_MODE_NONE : (pick == 1) ? ADDR_MODE_RESERVED :
         (pick < 6) ? i154rf_pkg::ADDR_MODE_SHORT : i154rf_pkg::ADDR_MODE_EXT;
    pick = $urandom_range(0, 9);
    sm = (pick == 0) ? i154rf_pkg::ADDR_MODE_NONE : (pick == 1) ? ADDR_MODE_RESERVED :
         (pick < 6) ? i154rf_pkg::ADDR_MODE_SHORT : i154rf_pkg::ADDR_MODE_EXT;
    sec = ($urandom_range(0, 3) == 0);
    pcomp = 1'($urandom);
    put_byte({1'($urandom), pcomp, ($urandom_range(0, 4) != 0), 1'($urandom), sec, ftype});
    put_byte({sm, 2'($urandom), dm, 2'($urandom)});
    put_byte(8'($urandom));
    if (dm != i154rf_pkg::ADDR_MODE_NONE) begin
      pick = $urandom_range(0, 9);
      id = (pick < 6) ? own_pan : (pick < 8) ? i154rf_pkg::BCAST_ID : 16'($urandom);
      put_byte(id[7:0]);
      put_byte(id[15:8]);
      if (dm == i154rf_pkg::ADDR_MODE_EXT) begin
        xa = own_ext;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          xa = {$urandom, $urandom};
        end else if (pick < 3) begin
          k = $urandom_range(0, 7);
          xa[8*k +: 8] = xa[8*k +: 8] ^ 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < 8; i++) put_byte(xa[8*i +: 8]);
      end else begin
        pick = $urandom_range(0, 9);
        id = (pick < 6) ? own_short : (pick < 8) ? i154rf_pkg::BCAST_ID : 16'($urandom);
        put_byte(id[7:0]);
        put_byte(id[15:8]);
      end
    end
    if (sm >= i154rf_pkg::ADDR_MODE_SHORT && !pcomp) begin
      repeat (2) put_byte(8'($urandom));
    end
    if (sm == i154rf_pkg::ADDR_MODE_SHORT) begin
      repeat (2) put_byte(8'($urandom));
    end else if (sm == i154rf_pkg::ADDR_MODE_EXT) begin
      repeat (8) put_byte(8'($urandom));
    end
    if (sec) begin
      sc = 8'($urandom);
      put_byte(sc);
      repeat (4 + KEY_ID_BYTES[sc[4:3]]) put_byte(8'($urandom));
    end
    if (ftype == i154rf_pkg::FRAME_TYPE_CMD) begin
      put_byte(($urandom_range(0, 9) < 7) ? i154rf_pkg::CMD_DATA_REQ : 8'($urandom));
    end
    // Payload plus the two FCS bytes.
    repeat ($urandom_range(0, 4) + 2) put_byte(8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      k = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 13);
      while (frame_len < k) put_byte(8'($urandom));
    end else if (pick < 18) begin
      frame_len = $urandom_range(1, frame_len);
    end
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_verdicts
    i154rf_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("unexpected result: verdict=%0d ack=%0d pending=%0d seq=%02h",
                   out_data.verdict, out_data.send_ack, out_data.ack_pending_bit,
                   out_data.ack_seq);
        end
      end else begin
        want = verdict_q.pop_front();
        if (out_data.verdict !== want.verdict || out_data.send_ack !== want.send_ack ||
            out_data.ack_pending_bit !== want.ack_pending_bit ||
            out_data.ack_seq !== want.ack_seq) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("mismatch: expected verdict=%0d ack=%0d pending=%0d seq=%02h",
                     want.verdict, want.send_ack, want.ack_pending_bit, want.ack_seq);
            $display("          got      verdict=%0d ack=%0d pending=%0d seq=%02h",
                     out_data.verdict, out_data.send_ack, out_data.ack_pending_bit,
                     out_data.ack_seq);
          end
        end
      end
    end
  end

  // Ends the run when no transaction completes on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int          phase_bytes;
    logic [63:0] prom;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = i154rf_pkg::REG_PAN_ID;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    program_regs(64'h0000_0000_0000_1234, 64'h0000_0000_0000_abcd, 64'h0123_4567_89ab_cdef,
                 64'h0);
    in_idle_pct = 25;
    out_idle_pct = 25;
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      send_byte(DIRECTED[i].frame_byte, DIRECTED[i].is_last, DIRECTED[i].typed,
                DIRECTED[i].want);
    end
    drain_results();

    for (int phase = 1; phase <= 6; phase++) begin
      prom = {$urandom, $urandom};
      case (phase)
        1: program_regs(64'h0, 64'h0, 64'h0, 64'h0);
        2: program_regs('1, '1, '1, 64'h0);
        3: program_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                        prom | 64'h1);
        6: program_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                        prom & ~64'h1);
        default: program_regs({$urandom, $urandom}, {$urandom, $urandom},
                              {$urandom, $urandom}, prom);
      endcase
      // The final phase runs both sides without idling.
      in_idle_pct = (phase == 6) ? 0 : $urandom_range(0, 40);
      out_idle_pct = (phase == 6) ? 0 : $urandom_range(0, 40);
      phase_bytes = 0;
      while (phase_bytes < 55) begin
        build_frame();
        for (int i = 0; i < frame_len; i++) begin
          send_byte(frame_buf[i], i == frame_len - 1, 1'b0, NO_VERDICT);
        end
        phase_bytes += frame_len;
      end
      drain_results();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/i154rf_pkg.sv
rtl/i154rf_capture.sv
rtl/ieee802154_rx_filter_autoack_unit.sv
tb/ieee802154_rx_filter_autoack_unit_tb.sv
